FILE: rtl/ata_pkg.sv
// Package for the accelerometer tilt filter: widths, the CORDIC cell record,
// the arctangent table and the fixed-point conversion helper.
// No dependencies.
`default_nettype none

package ata_pkg;

  localparam int SMP_W            = 16;
  localparam int COEF_W           = 16;
  localparam int SMOOTH_FRAC_BITS = 16;
  localparam int ST_W             = SMP_W + SMOOTH_FRAC_BITS;
  localparam int DIFF_W           = ST_W + 1;
  localparam int PROD_W           = DIFF_W + COEF_W + 1;
  localparam int WORK_FRAC        = 14;
  localparam int WORK_W           = SMP_W + WORK_FRAC;
  localparam int RAD_W            = 2 * WORK_W;
  localparam int SQ_CNT_W         = $clog2(WORK_W);
  localparam int CORDIC_STEPS     = 16;
  localparam int TABLE_LEN        = 24;
  localparam int IDX_W            = $clog2(TABLE_LEN);
  localparam int CX_W             = WORK_W + 4;
  localparam int ANG_W            = 26;
  localparam int ANG_FRAC         = 16;
  localparam int PITCH_W          = 15;
  localparam int ROLL_W           = 16;
  localparam int PITCH_LIMIT      = 11520;
  localparam int ROLL_LIMIT       = 23040;
  localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(655);

  typedef struct packed {
    logic                    vld;
    logic                    is_roll;
    logic                    zero;
    logic signed [CX_W-1:0]  x;
    logic signed [CX_W-1:0]  y;
    logic signed [ANG_W-1:0] ang;
  } cordic_t;

  // atan(2^-i) in 2^-16 degree, rounded to nearest.
  function automatic logic signed [ANG_W-1:0] atan_tab(input logic [IDX_W-1:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0:    v = ANG_W'(2949120);
      5'd1:    v = ANG_W'(1740967);
      5'd2:    v = ANG_W'(919879);
      5'd3:    v = ANG_W'(466945);
      5'd4:    v = ANG_W'(234379);
      5'd5:    v = ANG_W'(117304);
      5'd6:    v = ANG_W'(58666);
      5'd7:    v = ANG_W'(29335);
      5'd8:    v = ANG_W'(14668);
      5'd9:    v = ANG_W'(7334);
      5'd10:   v = ANG_W'(3667);
      5'd11:   v = ANG_W'(1833);
      5'd12:   v = ANG_W'(917);
      5'd13:   v = ANG_W'(458);
      5'd14:   v = ANG_W'(229);
      5'd15:   v = ANG_W'(115);
      5'd16:   v = ANG_W'(57);
      5'd17:   v = ANG_W'(29);
      5'd18:   v = ANG_W'(14);
      5'd19:   v = ANG_W'(7);
      5'd20:   v = ANG_W'(4);
      5'd21:   v = ANG_W'(2);
      5'd22:   v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Smoothed state to the working format with WORK_FRAC fraction bits (floor).
  function automatic logic signed [WORK_W-1:0] to_work(input logic signed [ST_W-1:0] s);
    logic signed [ST_W+WORK_FRAC-1:0] t;
    t = $signed({s, {WORK_FRAC{1'b0}}});
    t = t >>> SMOOTH_FRAC_BITS;
    return t[WORK_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ata_ifs.sv
// Handshake channels of the accelerometer tilt filter: configuration,
// sample input and angle output. Depends on ata_pkg.
`default_nettype none

interface ata_cfg_if;
  import ata_pkg::*;
  logic              valid;
  logic              ready;
  logic [COEF_W-1:0] smoothing_coeff;
  modport source (output valid, output smoothing_coeff, input ready);
  modport sink (input valid, input smoothing_coeff, output ready);
endinterface

interface ata_in_if;
  import ata_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] accel_x;
  logic signed [SMP_W-1:0] accel_y;
  logic signed [SMP_W-1:0] accel_z;
  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface ata_out_if;
  import ata_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [PITCH_W-1:0] pitch_deg;
  logic signed [ROLL_W-1:0]  roll_deg;
  modport source (output valid, output pitch_deg, output roll_deg, input ready);
  modport sink (input valid, input pitch_deg, input roll_deg, output ready);
endinterface

`default_nettype wire

FILE: rtl/ata_cordic_cell.sv
// One vectoring CORDIC cell: a single micro-rotation, registered.
// Depends on ata_pkg.
`default_nettype none

module ata_cordic_cell import ata_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  cordic_t          cell_i,
  output cordic_t          cell_o
);

  cordic_t cell_d;
  cordic_t cell_q;
  logic signed [CX_W-1:0] dx;
  logic signed [CX_W-1:0] dy;

  always_comb begin
    dx     = cell_i.y >>> idx_i;
    dy     = cell_i.x >>> idx_i;
    cell_d = cell_i;
    if (!cell_i.y[CX_W-1]) begin
      cell_d.x   = cell_i.x + dx;
      cell_d.y   = cell_i.y - dy;
      cell_d.ang = cell_i.ang + atan_tab(idx_i);
    end else begin
      cell_d.x   = cell_i.x - dx;
      cell_d.y   = cell_i.y + dy;
      cell_d.ang = cell_i.ang - atan_tab(idx_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

FILE: rtl/ata_isqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on ata_pkg.
`default_nettype none

module ata_isqrt import ata_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic              done_o,
  output logic [WORK_W-1:0] root_o
);

  logic                busy_q;
  logic                done_q;
  logic [SQ_CNT_W-1:0] cnt_q;
  logic [RAD_W-1:0]    rad_q;
  logic [WORK_W+1:0]   rem_q;
  logic [WORK_W-1:0]   root_q;
  logic [WORK_W+1:0]   rem_d;
  logic [WORK_W+1:0]   trial;
  logic                take;

  always_comb begin
    rem_d = {rem_q[WORK_W-1:0], rad_q[RAD_W-1 -: 2]};
    trial = {root_q, 2'b01};
    take  = (rem_d >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == SQ_CNT_W'(WORK_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (take) begin
        rem_q  <= rem_d - trial;
        root_q <= {root_q[WORK_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_d;
        root_q <= {root_q[WORK_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

FILE: rtl/accel_tilt_angle_filter.sv
// Accelerometer tilt filter top level: smoothing filters, magnitude unit and
// a row of CORDIC cells. Depends on ata_pkg, ata_ifs, ata_isqrt, ata_cordic_cell.
//
// Usage: cfg_ch writes the smoothing coefficient (unsigned Q0.16) and is always
// ready; write it only while the block is idle. Each in_ch beat carries one raw
// three-axis sample. The three exponential moving averages are updated, and
// one out_ch beat follows with pitch and roll in 1/128 degree, saturated to
// +/-90 and +/-180 degrees.
// From the input beat, the sample passes the difference, multiply, update,
// square and sum steps, the square root and then the 16-cell CORDIC row,
// pitch first and roll second. One sample is worked on at a time and the
// next is taken in the idle cycle after the result is loaded.
// The result sits in an output register; the next sample is accepted while it
// waits, and that sample's result waits in its last step until out_ch takes
// the earlier beat. A stalled receiver therefore holds back at most one
// further sample.
// Reset clears the filter states to zero, the coefficient to 655 and all
// valid flags, so no beat is in flight after reset.
`default_nettype none

module accel_tilt_angle_filter import ata_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ata_cfg_if.sink     cfg_ch,
  ata_in_if.sink      in_ch,
  ata_out_if.source   out_ch
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_UPD   = 4'd3;
  localparam logic [3:0] S_SQ    = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_PITCH = 4'd7;
  localparam logic [3:0] S_ROLL  = 4'd8;
  localparam logic [3:0] S_WAIT  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 <<< ANG_FRAC);

  logic [3:0] state_q;
  logic [3:0] state_d;

  logic [COEF_W-1:0]        coeff_q;
  logic signed [SMP_W-1:0]  smp_q    [3];
  logic signed [ST_W-1:0]   smooth_q [3];
  logic signed [DIFF_W-1:0] diff_q   [3];
  logic signed [PROD_W-1:0] prod_q   [3];
  logic [RAD_W-1:0]         sqy_q;
  logic [RAD_W-1:0]         sqz_q;
  logic signed [ANG_W-1:0]  pitch_ang_q;
  logic signed [ANG_W-1:0]  roll_ang_q;
  logic                     out_vld_q;
  logic signed [PITCH_W-1:0] pitch_q;
  logic signed [ROLL_W-1:0]  roll_q;

  logic                     in_fire;
  logic                     out_fire;
  logic                     out_load;
  logic                     sq_start;
  logic                     sq_done;
  logic [WORK_W-1:0]        root;
  logic signed [WORK_W-1:0] fx;
  logic signed [WORK_W-1:0] fy;
  logic signed [WORK_W-1:0] fz;
  logic signed [RAD_W-1:0]  sqy;
  logic signed [RAD_W-1:0]  sqz;
  logic signed [CX_W-1:0]   vx;
  logic signed [CX_W-1:0]   vy;
  cordic_t                  link [CORDIC_STEPS+1];
  cordic_t                  chain_out;

  // Round to 1/128 degree with halves going up, then clamp to +/-limit.
  function automatic logic signed [ROLL_W-1:0] to_out(input logic signed [ANG_W-1:0] a,
                                                      input logic signed [ROLL_W-1:0] lim);
    logic signed [ANG_W-1:0] v;
    v = (a + ANG_W'(1 <<< (ANG_FRAC - 8))) >>> (ANG_FRAC - 7);
    if (v > ANG_W'(lim)) begin
      v = ANG_W'(lim);
    end else if (v < -ANG_W'(lim)) begin
      v = -ANG_W'(lim);
    end
    return v[ROLL_W-1:0];
  endfunction

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_vld_q && out_ch.ready;
  assign out_load = (state_q == S_OUT) && (!out_vld_q || out_ch.ready);
  assign sq_start = (state_q == S_SUM);

  assign in_ch.ready  = (state_q == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign fx  = to_work(smooth_q[0]);
  assign fy  = to_work(smooth_q[1]);
  assign fz  = to_work(smooth_q[2]);
  assign sqy = fy * fy;
  assign sqz = fz * fz;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = S_DIFF;
      S_DIFF:  state_d = S_MUL;
      S_MUL:   state_d = S_UPD;
      S_UPD:   state_d = S_SQ;
      S_SQ:    state_d = S_SUM;
      S_SUM:   state_d = S_SQRT;
      S_SQRT:  if (sq_done) state_d = S_PITCH;
      S_PITCH: state_d = S_ROLL;
      S_ROLL:  state_d = S_WAIT;
      S_WAIT:  if (chain_out.vld && chain_out.is_roll) state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Vector for the chain: pitch uses (root, fx), roll uses (fz, -fy).
  // A vector in the left half-plane is first turned by 180 degrees.
  always_comb begin
    if (state_q == S_ROLL) begin
      vx = CX_W'(fz);
      vy = -CX_W'(fy);
    end else begin
      vx = CX_W'({1'b0, root});
      vy = CX_W'(fx);
    end
    link[0].vld     = (state_q == S_PITCH) || (state_q == S_ROLL);
    link[0].is_roll = (state_q == S_ROLL);
    link[0].zero    = (vx == '0) && (vy == '0);
    link[0].x       = vx;
    link[0].y       = vy;
    link[0].ang     = '0;
    if (vx[CX_W-1]) begin
      link[0].x   = -vx;
      link[0].y   = -vy;
      link[0].ang = vy[CX_W-1] ? -ANG_180 : ANG_180;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    ata_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(g)),
      .cell_i (link[g]),
      .cell_o (link[g+1])
    );
  end

  assign chain_out = link[CORDIC_STEPS];

  ata_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sqy_q + sqz_q),
    .done_o  (sq_done),
    .root_o  (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      coeff_q   <= COEF_RESET;
      out_vld_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        smooth_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_ch.valid && cfg_ch.ready) begin
        coeff_q <= cfg_ch.smoothing_coeff;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_fire) begin
        out_vld_q <= 1'b0;
      end
      if (state_q == S_UPD) begin
        for (int k = 0; k < 3; k++) begin
          smooth_q[k] <= smooth_q[k] + prod_q[k][COEF_W +: ST_W];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      smp_q[0] <= in_ch.accel_x;
      smp_q[1] <= in_ch.accel_y;
      smp_q[2] <= in_ch.accel_z;
    end
    for (int k = 0; k < 3; k++) begin
      if (state_q == S_DIFF) begin
        diff_q[k] <= DIFF_W'($signed({smp_q[k], {SMOOTH_FRAC_BITS{1'b0}}}))
                     - DIFF_W'(smooth_q[k]);
      end
      if (state_q == S_MUL) begin
        prod_q[k] <= diff_q[k] * $signed({1'b0, coeff_q});
      end
    end
    if (state_q == S_SQ) begin
      sqy_q <= sqy;
      sqz_q <= sqz;
    end
    if (chain_out.vld) begin
      if (chain_out.is_roll) begin
        roll_ang_q <= chain_out.zero ? '0 : chain_out.ang;
      end else begin
        pitch_ang_q <= chain_out.zero ? '0 : chain_out.ang;
      end
    end
    if (out_load) begin
      pitch_q <= PITCH_W'(to_out(pitch_ang_q, ROLL_W'(PITCH_LIMIT)));
      roll_q  <= to_out(roll_ang_q, ROLL_W'(ROLL_LIMIT));
    end
  end

  assign out_ch.valid     = out_vld_q;
  assign out_ch.pitch_deg = pitch_q;
  assign out_ch.roll_deg  = roll_q;

  // A sample in flight blocks the next one until its result is loaded.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ch.ready)
    else $error("input accepted while a sample is in flight");

  // The square root only finishes while the controller waits for it.
  a_sqrt_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (state_q == S_SQRT))
    else $error("square root finished outside its wait state");

  // Results stay inside the saturation limits.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (pitch_q <= PITCH_W'(PITCH_LIMIT)) && (pitch_q >= -PITCH_W'(PITCH_LIMIT))
               && (roll_q <= ROLL_W'(ROLL_LIMIT)) && (roll_q >= -ROLL_W'(ROLL_LIMIT)))
    else $error("angle result outside its limit");

endmodule

`default_nettype wire
